/* rtl/rounded_rect_alpha_blend_unit_defines.svh */
// assertion macros for the rounded rect alpha blend unit
// used by the checker module, no other dependencies
`ifndef ROUNDED_RECT_ALPHA_BLEND_UNIT_DEFINES_SVH
`define ROUNDED_RECT_ALPHA_BLEND_UNIT_DEFINES_SVH

// clocked assertion, disabled while reset is high
`define RRAB_ASSERT_RST(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds through reset
`define RRAB_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/rrab_pkg.sv */
// shared types, constants and helper functions for the rounded rect alpha blend unit
// no dependencies
`default_nettype none

package rrab_pkg;

  localparam int SIZE_BITS      = 13;
  localparam int RAD_BITS       = 12;
  localparam int COLOR_BITS     = 24;
  localparam int ALPHA_BITS     = 8;
  localparam int SHIFT_BITS     = 5;
  localparam int PIX_BITS       = 32;
  localparam int CH_BITS        = 8;
  localparam int MIX_BITS       = 2 * CH_BITS;
  localparam int SQ_BITS        = 2 * RAD_BITS;
  localparam int CFG_DATA_BITS  = 24;
  localparam int CFG_INDEX_BITS = 3;

  localparam logic [CFG_INDEX_BITS-1:0] REG_RECT_WIDTH    = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RECT_HEIGHT   = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CORNER_RADIUS = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BLEND_COLOR   = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BLEND_ALPHA   = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RED_SHIFT     = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GREEN_SHIFT   = 3'd6;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BLUE_SHIFT    = 3'd7;

  localparam logic [ALPHA_BITS-1:0] ALPHA_FULL        = 8'd255;
  localparam logic [SHIFT_BITS-1:0] RED_SHIFT_RESET   = 5'd16;
  localparam logic [SHIFT_BITS-1:0] GREEN_SHIFT_RESET = 5'd8;
  localparam logic [SHIFT_BITS-1:0] BLUE_SHIFT_RESET  = 5'd0;

  typedef struct packed {
    logic [SIZE_BITS-1:0]  rect_width;
    logic [SIZE_BITS-1:0]  rect_height;
    logic [RAD_BITS-1:0]   corner_radius;
    logic [COLOR_BITS-1:0] blend_color;
    logic [ALPHA_BITS-1:0] blend_alpha;
    logic [SHIFT_BITS-1:0] red_shift;
    logic [SHIFT_BITS-1:0] green_shift;
    logic [SHIFT_BITS-1:0] blue_shift;
  } cfg_t;

  typedef struct packed {
    logic s1_en;
    logic s2_en;
    logic s3_en;
  } pipe_ctl_t;

  function automatic logic [CH_BITS-1:0] take_byte(input logic [PIX_BITS-1:0] word,
                                                   input logic [SHIFT_BITS-1:0] pos);
    logic [PIX_BITS-1:0] sh;
    sh = word >> pos;
    return sh[CH_BITS-1:0];
  endfunction

  function automatic logic [PIX_BITS-1:0] place_byte(input logic [CH_BITS-1:0] v,
                                                     input logic [SHIFT_BITS-1:0] pos);
    logic [PIX_BITS-1:0] w;
    w = {{(PIX_BITS-CH_BITS){1'b0}}, v} << pos;
    return w;
  endfunction

  // exact x / 255 for x up to 255 * 255
  function automatic logic [CH_BITS-1:0] div255(input logic [MIX_BITS-1:0] x);
    logic [MIX_BITS-1:0] s;
    s = x + {{CH_BITS{1'b0}}, x[MIX_BITS-1:CH_BITS]} + MIX_BITS'(1);
    return s[MIX_BITS-1:CH_BITS];
  endfunction

endpackage

`default_nettype wire

/* rtl/rounded_rect_alpha_blend_unit.sv */
// path: a transferred pixel is registered in stage 1, stage 2, then the stage 3 output register
// throughput: one pixel per cycle; each of the three stages holds while the next is full
// and stalled, and an empty stage takes new data even while the output is stalled
// reset: rst clears all stage valid bits and loads the register reset values
// depends on rrab_pkg, rrab_cfg, rrab_shape, rrab_blend
`default_nettype none

module rounded_rect_alpha_blend_unit
  import rrab_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [COORD_BITS-1:0]     col,
  input  wire logic [COORD_BITS-1:0]     row,
  input  wire logic [PIX_BITS-1:0]       dest_pixel,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [PIX_BITS-1:0]            new_pixel,
  output logic                           write_enable
);

  cfg_t                cfg;
  pipe_ctl_t           ctl;
  logic                v1, v2, v3;
  logic                covered;
  logic [PIX_BITS-1:0] blended, passed;

  assign ctl.s3_en = !v3 || !out_stall;
  assign ctl.s2_en = !v2 || ctl.s3_en;
  assign ctl.s1_en = !v1 || ctl.s2_en;
  assign in_stall  = !ctl.s1_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (ctl.s1_en) begin
        v1 <= in_valid;
      end
      if (ctl.s2_en) begin
        v2 <= v1;
      end
      if (ctl.s3_en) begin
        v3 <= v2;
      end
    end
  end

  rrab_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rrab_shape #(
    .COORD_BITS (COORD_BITS)
  ) u_shape (
    .clk     (clk),
    .ctl     (ctl),
    .cfg     (cfg),
    .col     (col),
    .row     (row),
    .covered (covered)
  );

  rrab_blend u_blend (
    .clk        (clk),
    .ctl        (ctl),
    .cfg        (cfg),
    .dest_pixel (dest_pixel),
    .blended    (blended),
    .passed     (passed)
  );

  assign out_valid    = v3;
  assign write_enable = covered;
  assign new_pixel    = covered ? blended : passed;

endmodule

`default_nettype wire

/* rtl/rrab_cfg.sv */
// configuration register file of the rounded rect alpha blend unit
// depends on rrab_pkg
`default_nettype none

module rrab_cfg
  import rrab_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
  output cfg_t                           cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rect_width    <= '0;
      cfg.rect_height   <= '0;
      cfg.corner_radius <= '0;
      cfg.blend_color   <= '0;
      cfg.blend_alpha   <= ALPHA_FULL;
      cfg.red_shift     <= RED_SHIFT_RESET;
      cfg.green_shift   <= GREEN_SHIFT_RESET;
      cfg.blue_shift    <= BLUE_SHIFT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RECT_WIDTH:    cfg.rect_width    <= cfg_data[SIZE_BITS-1:0];
        REG_RECT_HEIGHT:   cfg.rect_height   <= cfg_data[SIZE_BITS-1:0];
        REG_CORNER_RADIUS: cfg.corner_radius <= cfg_data[RAD_BITS-1:0];
        REG_BLEND_COLOR:   cfg.blend_color   <= cfg_data[COLOR_BITS-1:0];
        REG_BLEND_ALPHA:   cfg.blend_alpha   <= cfg_data[ALPHA_BITS-1:0];
        REG_RED_SHIFT:     cfg.red_shift     <= cfg_data[SHIFT_BITS-1:0];
        REG_GREEN_SHIFT:   cfg.green_shift   <= cfg_data[SHIFT_BITS-1:0];
        REG_BLUE_SHIFT:    cfg.blue_shift    <= cfg_data[SHIFT_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/rrab_shape.sv */
// three-stage rounded rectangle coverage test: bounds and corner offsets,
// squares, then distance compare; depends on rrab_pkg
`default_nettype none

module rrab_shape
  import rrab_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  wire logic                  clk,
  input  wire pipe_ctl_t             ctl,
  input  wire cfg_t                  cfg,
  input  wire logic [COORD_BITS-1:0] col,
  input  wire logic [COORD_BITS-1:0] row,
  output logic                       covered
);

  localparam int SW = ((COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS) + 2;

  logic [SW-1:0]       px, py, wsz, hsz, rad;
  logic [SW-1:0]       dx_full, dy_full;
  logic                in_bounds;

  logic                inb1;
  logic [RAD_BITS-1:0] dx1, dy1;
  logic                inb2;
  logic [SQ_BITS-1:0]  dxsq2, dysq2, radsq2;

  assign px  = SW'(col);
  assign py  = SW'(row);
  assign wsz = SW'(cfg.rect_width);
  assign hsz = SW'(cfg.rect_height);
  assign rad = SW'(cfg.corner_radius);

  assign in_bounds = (px < wsz) && (py < hsz);

  // offset from the inset corner point, bounded by the radius when in bounds
  always_comb begin
    priority if (px < rad) begin
      dx_full = rad - px;
    end else if (px + rad >= wsz) begin
      dx_full = px + rad + SW'(1) - wsz;
    end else begin
      dx_full = '0;
    end
    priority if (py < rad) begin
      dy_full = rad - py;
    end else if (py + rad >= hsz) begin
      dy_full = py + rad + SW'(1) - hsz;
    end else begin
      dy_full = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.s1_en) begin
      inb1 <= in_bounds;
      dx1  <= dx_full[RAD_BITS-1:0];
      dy1  <= dy_full[RAD_BITS-1:0];
    end
    if (ctl.s2_en) begin
      inb2   <= inb1;
      dxsq2  <= SQ_BITS'(dx1) * SQ_BITS'(dx1);
      dysq2  <= SQ_BITS'(dy1) * SQ_BITS'(dy1);
      radsq2 <= SQ_BITS'(cfg.corner_radius) * SQ_BITS'(cfg.corner_radius);
    end
    if (ctl.s3_en) begin
      covered <= inb2 && (({1'b0, dxsq2} + {1'b0, dysq2}) <= {1'b0, radsq2});
    end
  end

endmodule

`default_nettype wire

/* rtl/rrab_blend.sv */
// three-stage channel blend: unpack, weighted products, divide by 255 and repack
// depends on rrab_pkg
`default_nettype none

module rrab_blend
  import rrab_pkg::*;
(
  input  wire logic                clk,
  input  wire pipe_ctl_t           ctl,
  input  wire cfg_t                cfg,
  input  wire logic [PIX_BITS-1:0] dest_pixel,
  output logic [PIX_BITS-1:0]      blended,
  output logic [PIX_BITS-1:0]      passed
);

  logic [CH_BITS-1:0]  dr1, dg1, db1;
  logic [PIX_BITS-1:0] dest1, dest2;
  logic [MIX_BITS-1:0] mr2, mg2, mb2;
  logic [CH_BITS-1:0]  sr, sg, sb, a, ia;

  assign sr = cfg.blend_color[23:16];
  assign sg = cfg.blend_color[15:8];
  assign sb = cfg.blend_color[7:0];
  assign a  = cfg.blend_alpha;
  assign ia = ALPHA_FULL - cfg.blend_alpha;

  always_ff @(posedge clk) begin
    if (ctl.s1_en) begin
      dr1   <= take_byte(dest_pixel, cfg.red_shift);
      dg1   <= take_byte(dest_pixel, cfg.green_shift);
      db1   <= take_byte(dest_pixel, cfg.blue_shift);
      dest1 <= dest_pixel;
    end
    if (ctl.s2_en) begin
      mr2   <= {8'd0, sr} * {8'd0, a} + {8'd0, dr1} * {8'd0, ia};
      mg2   <= {8'd0, sg} * {8'd0, a} + {8'd0, dg1} * {8'd0, ia};
      mb2   <= {8'd0, sb} * {8'd0, a} + {8'd0, db1} * {8'd0, ia};
      dest2 <= dest1;
    end
    if (ctl.s3_en) begin
      blended <= place_byte(div255(mr2), cfg.red_shift)
               | place_byte(div255(mg2), cfg.green_shift)
               | place_byte(div255(mb2), cfg.blue_shift);
      passed  <= dest2;
    end
  end

endmodule

`default_nettype wire

/* rtl/rrab_checker.sv */
// port-level checker for the rounded rect alpha blend unit and its bind
// depends on rounded_rect_alpha_blend_unit_defines.svh and rrab_pkg
`default_nettype none
`include "rounded_rect_alpha_blend_unit_defines.svh"

module rrab_checker
  import rrab_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire logic [PIX_BITS-1:0] new_pixel,
  input wire logic                write_enable
);

  `RRAB_ASSERT_ALWAYS(a_reset_empties, clk, rst |=> !out_valid, "output valid after reset")
  `RRAB_ASSERT_RST(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable(new_pixel) && $stable(write_enable), "stalled output transfer changed")
  `RRAB_ASSERT_RST(a_no_false_stall, clk, rst, !out_valid || !out_stall |-> !in_stall, "input stalled with output free")
  `RRAB_ASSERT_RST(a_latency, clk, rst, in_valid && !in_stall ##1 !out_stall ##1 !out_stall |=> out_valid, "pixel not out after three cycles")

endmodule

bind rounded_rect_alpha_blend_unit rrab_checker u_rrab_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .new_pixel    (new_pixel),
  .write_enable (write_enable)
);

`default_nettype wire
